// ===== hw/rtl/bgla_pkg.sv =====
// Shared types, constants and coefficient tables of the battery gauge low alarm.
`default_nettype none
package bgla_pkg;

  // Field and register widths
  localparam int MV_W      = 16;
  localparam int OFS_W     = 13;
  localparam int HYS_W     = 12;
  localparam int TICK_W    = 10;
  localparam int MS_W      = 16;
  localparam int Q15_W     = 16;
  localparam int PCT_W     = 7;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  // Datapath widths: accumulator and coefficients in Q12.30, volts in Q6.16
  localparam int ACC_W     = 42;
  localparam int V_W       = 22;
  localparam int PROD_W    = 64;
  localparam int Q_W       = ACC_W - 15;

  // Segment limits and alarm floor in millivolts
  localparam logic [MV_W-1:0] SEG_LOW_MV   = 16'd19500;
  localparam logic [MV_W-1:0] SEG_MID_MV   = 16'd21900;
  localparam logic [MV_W-1:0] SEG_HIGH_MV  = 16'd25500;
  localparam logic [MV_W-1:0] ALARM_MIN_MV = 16'd1000;
  localparam logic [Q15_W-1:0] Q15_ONE     = 16'd32768;

  // mV to Q6.16: v = (mv * VOLT_MUL + VOLT_BIAS) >> VOLT_SHIFT, exact for the segment range
  localparam logic signed [ACC_W-1:0]  VOLT_MUL   = 42'sd1125899911168;
  localparam logic signed [PROD_W-1:0] VOLT_BIAS  = 64'sd8521215148;
  localparam int                       VOLT_SHIFT = 34;
  localparam int                       HORNER_SHIFT = 16;

  // Register map indexes
  typedef enum logic [2:0] {
    REG_DROP_OFFSET = 3'd0,
    REG_LOW_THRESH  = 3'd1,
    REG_HYSTERESIS  = 3'd2,
    REG_TICK        = 3'd3,
    REG_BEEP_ON     = 3'd4,
    REG_BEEP_OFF    = 3'd5
  } reg_idx_t;

  // Operation of the shared multiply unit
  typedef enum logic {
    MAC_VOLT   = 1'b0,
    MAC_HORNER = 1'b1
  } mac_op_t;

  // Configuration register set
  typedef struct packed {
    logic [OFS_W-1:0]  drop_offset_mv;
    logic [MV_W-1:0]   low_threshold_mv;
    logic [HYS_W-1:0]  hysteresis_mv;
    logic [TICK_W-1:0] tick_ms;
    logic [MS_W-1:0]   beep_on_ms;
    logic [MS_W-1:0]   beep_off_ms;
  } cfg_t;

  // Alarm and buzzer flags for one item
  typedef struct packed {
    logic low_alarm;
    logic buzzer_on;
    logic tone_start;
    logic tone_stop;
  } alarm_res_t;

  // Cubic coefficients in Q12.30, highest power first
  function automatic logic signed [ACC_W-1:0] seg_coef(input logic seg_hi,
                                                       input logic [1:0] k);
    logic signed [ACC_W-1:0] c;
    c = '0;
    if (!seg_hi) begin
      unique case (k)
        2'd0: c = 42'sd6081674;
        2'd1: c = -42'sd363568982;
        2'd2: c = 42'sd7263863439;
        2'd3: c = -42'sd48500918190;
        default: c = '0;
      endcase
    end else begin
      unique case (k)
        2'd0: c = 42'sd24363202;
        2'd1: c = -42'sd1775968977;
        2'd2: c = 42'sd43314745180;
        2'd3: c = -42'sd352616815002;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bgla_if.sv =====
// Valid/ready channel interfaces for samples and gauge results.
`default_nettype none
interface bgla_in_if;
  logic                        valid;
  logic                        ready;
  logic [bgla_pkg::MV_W-1:0]   sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bgla_out_if;
  logic                        valid;
  logic                        ready;
  logic [bgla_pkg::MV_W-1:0]   voltage_mv;
  logic [bgla_pkg::Q15_W-1:0]  charge_q15;
  logic [bgla_pkg::PCT_W-1:0]  percent_whole;
  logic                        low_alarm;
  logic                        buzzer_on;
  logic                        tone_start;
  logic                        tone_stop;

  modport source (output valid, output voltage_mv, output charge_q15, output percent_whole,
                  output low_alarm, output buzzer_on, output tone_start, output tone_stop,
                  input ready);
  modport sink   (input valid, input voltage_mv, input charge_q15, input percent_whole,
                  input low_alarm, input buzzer_on, input tone_start, input tone_stop,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/battery_gauge_low_alarm.sv =====
// Battery gauge top level: sequencer around the shared multiply unit, alarm and output register.
// Sequence: for 19500..25499 mV, four multiply steps, each a multiply and an add state on the one
//   shared multiplier, then the commit; other samples go straight to the commit.
// Samples: a new sample is taken only once the sequencer is back in idle, so samples do not overlap;
//   a held result in the output register stalls only the final commit.
// Reset: synchronous active-low rst_n clears the sequencer, alarm, buzzer and output valid,
//   and loads the register defaults.
`default_nettype none
module battery_gauge_low_alarm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bgla_in_if.sink                                in_ch,
  bgla_out_if.source                             out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bgla_pkg::PADDR_W-1:0]      cfg_paddr,
  input  wire logic [bgla_pkg::PDATA_W-1:0]      cfg_pwdata,
  output logic      [bgla_pkg::PDATA_W-1:0]      cfg_prdata,
  output logic                                   cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [1:0]                            step_r, step_nxt;
  logic [bgla_pkg::MV_W-1:0]             mv_r, mv_nxt;
  logic                                  seg_hi_r;
  logic signed [bgla_pkg::V_W-1:0]       v_r;
  logic signed [bgla_pkg::ACC_W-1:0]     acc_r;
  logic                                  out_valid_r, out_valid_nxt;
  logic [bgla_pkg::MV_W-1:0]             out_mv_r;
  logic [bgla_pkg::Q15_W-1:0]            out_charge_r;
  logic [bgla_pkg::PCT_W-1:0]            out_pct_r;
  bgla_pkg::alarm_res_t                  out_flags_r;

  bgla_pkg::cfg_t                        cfg;
  bgla_pkg::alarm_res_t                  flags;
  bgla_pkg::mac_op_t                     mac_op;
  logic signed [bgla_pkg::ACC_W-1:0]     mac_a, mac_c, mac_res;
  logic signed [bgla_pkg::V_W-1:0]       mac_b;
  logic                                  accept, issue, commit, in_seg;
  logic signed [bgla_pkg::MV_W+1:0]      corr_sum;
  logic signed [bgla_pkg::Q_W-1:0]       q_full;
  logic [bgla_pkg::Q15_W-1:0]            charge;
  logic [bgla_pkg::Q15_W+6:0]            pct_prod;

  bgla_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  bgla_mac u_mac (
    .clk   (clk),
    .issue (issue),
    .op    (mac_op),
    .a     (mac_a),
    .b     (mac_b),
    .c     (mac_c),
    .res   (mac_res)
  );

  bgla_alarm u_alarm (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .mv     (mv_r),
    .cfg    (cfg),
    .res    (flags)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign issue       = (state_r == ST_MUL);
  assign commit      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // Apply the drop offset and saturate to the 16-bit range
  assign corr_sum = $signed({2'b00, in_ch.sample_mv})
                  + (bgla_pkg::MV_W+2)'($signed(cfg.drop_offset_mv));
  always_comb begin
    priority if (corr_sum < 0) begin
      mv_nxt = '0;
    end else if (corr_sum[bgla_pkg::MV_W]) begin
      mv_nxt = '1;
    end else begin
      mv_nxt = corr_sum[bgla_pkg::MV_W-1:0];
    end
  end
  assign in_seg = (mv_nxt >= bgla_pkg::SEG_LOW_MV) && (mv_nxt < bgla_pkg::SEG_HIGH_MV);

  // Step zero converts mV to Q6.16 volts, steps one to three run Horner
  assign mac_op = (step_r == 2'd0) ? bgla_pkg::MAC_VOLT : bgla_pkg::MAC_HORNER;
  assign mac_a  = (step_r == 2'd0) ? bgla_pkg::VOLT_MUL : acc_r;
  assign mac_b  = (step_r == 2'd0) ? $signed(bgla_pkg::V_W'(mv_r)) : v_r;
  assign mac_c  = bgla_pkg::seg_coef(seg_hi_r, step_r);

  // Sequence the multiply steps
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          step_nxt  = '0;
          state_nxt = in_seg ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: begin
        if (step_r == 2'd3) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Hold the corrected voltage and the Horner accumulator
  always_ff @(posedge clk) begin
    if (accept) begin
      mv_r     <= mv_nxt;
      seg_hi_r <= (mv_nxt >= bgla_pkg::SEG_MID_MV);
    end
    if (state_r == ST_ADD) begin
      if (step_r == 2'd0) begin
        v_r   <= mac_res[bgla_pkg::V_W-1:0];
        acc_r <= bgla_pkg::seg_coef(seg_hi_r, 2'd0);
      end else begin
        acc_r <= mac_res;
      end
    end
  end

  // Clamp the charge and scale to whole percent
  assign q_full = acc_r[bgla_pkg::ACC_W-1:15];
  always_comb begin
    priority if (mv_r < bgla_pkg::SEG_LOW_MV) begin
      charge = '0;
    end else if (mv_r >= bgla_pkg::SEG_HIGH_MV) begin
      charge = bgla_pkg::Q15_ONE;
    end else if (q_full < 0) begin
      charge = '0;
    end else if (q_full > $signed(bgla_pkg::Q_W'(bgla_pkg::Q15_ONE))) begin
      charge = bgla_pkg::Q15_ONE;
    end else begin
      charge = q_full[bgla_pkg::Q15_W-1:0];
    end
  end
  assign pct_prod = ((bgla_pkg::Q15_W+7)'(charge) << 6) + ((bgla_pkg::Q15_W+7)'(charge) << 5)
                  + ((bgla_pkg::Q15_W+7)'(charge) << 2);

  // Output register: load on commit, drop when taken
  assign out_valid_nxt = commit ? 1'b1 : (out_valid_r && !out_ch.ready);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_mv_r     <= mv_r;
      out_charge_r <= charge;
      out_pct_r    <= pct_prod[bgla_pkg::Q15_W+5:15];
      out_flags_r  <= flags;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.voltage_mv    = out_mv_r;
  assign out_ch.charge_q15    = out_charge_r;
  assign out_ch.percent_whole = out_pct_r;
  assign out_ch.low_alarm     = out_flags_r.low_alarm;
  assign out_ch.buzzer_on     = out_flags_r.buzzer_on;
  assign out_ch.tone_start    = out_flags_r.tone_start;
  assign out_ch.tone_stop     = out_flags_r.tone_stop;

  // A buzzer edge pulse never pairs with the opposite buzzer level
  a_start_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.tone_start |-> out_ch.buzzer_on && !out_ch.tone_stop)
    else $error("tone start without buzzer on");

  a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.tone_stop |-> !out_ch.buzzer_on)
    else $error("tone stop with buzzer on");

  // Charge stays within Q1.15 full scale and percent follows it
  a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.charge_q15 <= bgla_pkg::Q15_ONE && out_ch.percent_whole <= 7'd100)
    else $error("charge out of range");

  // The buzzer sounds only while the alarm holds
  a_buzz_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.buzzer_on |-> out_ch.low_alarm)
    else $error("buzzer on without alarm");

endmodule
`default_nettype wire

// ===== hw/rtl/bgla_cfg.sv =====
// APB configuration registers of the battery gauge low alarm.
`default_nettype none
module bgla_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bgla_pkg::PADDR_W-1:0]      cfg_paddr,
  input  wire logic [bgla_pkg::PDATA_W-1:0]      cfg_pwdata,
  output logic      [bgla_pkg::PDATA_W-1:0]      cfg_prdata,
  output logic                                   cfg_pready,
  output bgla_pkg::cfg_t                         cfg_o
);

  bgla_pkg::cfg_t   cfg_r;
  logic             wr_en;
  bgla_pkg::reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = bgla_pkg::reg_idx_t'(cfg_paddr[bgla_pkg::PADDR_W-1:2]);
  assign cfg_o      = cfg_r;

  // Write the addressed register; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_offset_mv   <= '0;
      cfg_r.low_threshold_mv <= 16'd21000;
      cfg_r.hysteresis_mv    <= 12'd500;
      cfg_r.tick_ms          <= 10'd100;
      cfg_r.beep_on_ms       <= 16'd120;
      cfg_r.beep_off_ms      <= 16'd160;
    end else if (wr_en) begin
      unique case (idx)
        bgla_pkg::REG_DROP_OFFSET:
          cfg_r.drop_offset_mv   <= cfg_pwdata[bgla_pkg::OFS_W-1:0];
        bgla_pkg::REG_LOW_THRESH:
          cfg_r.low_threshold_mv <= cfg_pwdata[bgla_pkg::MV_W-1:0];
        bgla_pkg::REG_HYSTERESIS:
          cfg_r.hysteresis_mv    <= cfg_pwdata[bgla_pkg::HYS_W-1:0];
        bgla_pkg::REG_TICK:
          cfg_r.tick_ms          <= cfg_pwdata[bgla_pkg::TICK_W-1:0];
        bgla_pkg::REG_BEEP_ON:
          cfg_r.beep_on_ms       <= cfg_pwdata[bgla_pkg::MS_W-1:0];
        bgla_pkg::REG_BEEP_OFF:
          cfg_r.beep_off_ms      <= cfg_pwdata[bgla_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero extended
  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      bgla_pkg::REG_DROP_OFFSET: cfg_prdata = bgla_pkg::PDATA_W'(cfg_r.drop_offset_mv);
      bgla_pkg::REG_LOW_THRESH:  cfg_prdata = bgla_pkg::PDATA_W'(cfg_r.low_threshold_mv);
      bgla_pkg::REG_HYSTERESIS:  cfg_prdata = bgla_pkg::PDATA_W'(cfg_r.hysteresis_mv);
      bgla_pkg::REG_TICK:        cfg_prdata = bgla_pkg::PDATA_W'(cfg_r.tick_ms);
      bgla_pkg::REG_BEEP_ON:     cfg_prdata = bgla_pkg::PDATA_W'(cfg_r.beep_on_ms);
      bgla_pkg::REG_BEEP_OFF:    cfg_prdata = bgla_pkg::PDATA_W'(cfg_r.beep_off_ms);
      default:                   cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bgla_mac.sv =====
// Shared multiply unit with registered product and shift-add back end.
`default_nettype none
module bgla_mac (
  input  wire logic                                  clk,
  input  wire logic                                  issue,
  input  wire bgla_pkg::mac_op_t                     op,
  input  wire logic signed [bgla_pkg::ACC_W-1:0]     a,
  input  wire logic signed [bgla_pkg::V_W-1:0]       b,
  input  wire logic signed [bgla_pkg::ACC_W-1:0]     c,
  output logic signed      [bgla_pkg::ACC_W-1:0]     res
);

  logic signed [bgla_pkg::PROD_W-1:0] prod_r;
  logic signed [bgla_pkg::PROD_W-1:0] prod_nxt;
  bgla_pkg::mac_op_t                  op_r;
  logic signed [bgla_pkg::PROD_W-1:0] volt_sum;
  logic signed [bgla_pkg::PROD_W-1:0] volt_q;
  logic signed [bgla_pkg::PROD_W-1:0] horn_q;

  assign prod_nxt = bgla_pkg::PROD_W'(a) * bgla_pkg::PROD_W'(b);

  // Capture the product and its operation
  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= prod_nxt;
      op_r   <= op;
    end
  end

  // Scale the product: rounding reciprocal for volts, floor shift plus coefficient for Horner
  assign volt_sum = prod_r + bgla_pkg::VOLT_BIAS;
  assign volt_q   = volt_sum >>> bgla_pkg::VOLT_SHIFT;
  assign horn_q   = prod_r >>> bgla_pkg::HORNER_SHIFT;

  always_comb begin
    unique case (op_r)
      bgla_pkg::MAC_VOLT:   res = volt_q[bgla_pkg::ACC_W-1:0];
      bgla_pkg::MAC_HORNER: res = horn_q[bgla_pkg::ACC_W-1:0] + c;
      default:              res = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bgla_alarm.sv =====
// Low alarm with hysteresis and buzzer cadence state.
`default_nettype none
module bgla_alarm (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          commit,
  input  wire logic [bgla_pkg::MV_W-1:0]     mv,
  input  wire bgla_pkg::cfg_t                cfg,
  output bgla_pkg::alarm_res_t               res
);

  logic                        alarm_r, alarm_nxt;
  logic                        beep_r, beep_nxt;
  logic [bgla_pkg::MS_W-1:0]   elapsed_r, elapsed_nxt;
  logic [bgla_pkg::MS_W:0]     clear_level;
  logic [bgla_pkg::MS_W:0]     elapsed_sum;
  logic [bgla_pkg::MS_W-1:0]   elapsed_sat;
  logic                        start, stop;

  assign clear_level = {1'b0, cfg.low_threshold_mv} + (bgla_pkg::MS_W+1)'(cfg.hysteresis_mv);
  assign elapsed_sum = {1'b0, elapsed_r} + (bgla_pkg::MS_W+1)'(cfg.tick_ms);
  assign elapsed_sat = elapsed_sum[bgla_pkg::MS_W] ? '1 : elapsed_sum[bgla_pkg::MS_W-1:0];

  // Raise, clear or hold the alarm, then advance the buzzer cadence
  always_comb begin
    alarm_nxt   = alarm_r;
    beep_nxt    = beep_r;
    elapsed_nxt = elapsed_r;
    start       = 1'b0;
    stop        = 1'b0;
    if (mv > bgla_pkg::ALARM_MIN_MV && mv <= cfg.low_threshold_mv) begin
      alarm_nxt = 1'b1;
    end else if ({1'b0, mv} > clear_level) begin
      alarm_nxt = 1'b0;
    end
    priority if (!alarm_nxt) begin
      stop        = beep_r;
      beep_nxt    = 1'b0;
      elapsed_nxt = '0;
    end else if (!alarm_r) begin
      beep_nxt    = 1'b1;
      elapsed_nxt = '0;
      start       = 1'b1;
    end else begin
      elapsed_nxt = elapsed_sat;
      if (beep_r) begin
        if (elapsed_sat >= cfg.beep_on_ms) begin
          beep_nxt    = 1'b0;
          elapsed_nxt = '0;
          stop        = 1'b1;
        end
      end else if (elapsed_sat >= cfg.beep_off_ms) begin
        beep_nxt    = 1'b1;
        elapsed_nxt = '0;
        start       = 1'b1;
      end
    end
  end

  // Commit state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r   <= 1'b0;
      beep_r    <= 1'b0;
      elapsed_r <= '0;
    end else if (commit) begin
      alarm_r   <= alarm_nxt;
      beep_r    <= beep_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign res.low_alarm  = alarm_nxt;
  assign res.buzzer_on  = beep_nxt;
  assign res.tone_start = start;
  assign res.tone_stop  = stop;

endmodule
`default_nettype wire
